// ===== rtl/sact_pkg.sv =====
`timescale 1ns / 1ps
package sact_pkg;
    localparam int SET_COUNT = 256;
    localparam int WAY_COUNT = 8;
    localparam int ADDR_BITS = 32;
    localparam int SET_W     = $clog2(SET_COUNT);
    localparam int WAY_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int WCNT_W    = $clog2(WAY_COUNT + 1);
    localparam int LINES     = SET_COUNT * WAY_COUNT;
    localparam int LINE_W    = $clog2(LINES);
    // line entry: valid, dirty, tag and stamp
    localparam int ENT_W     = 66;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_SETBITS = 2'd1;
    localparam logic [1:0] CFG_WAYS   = 2'd2;

    localparam logic FUNC_LOOKUP  = 1'b0;
    localparam logic FUNC_INSTALL = 1'b1;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    typedef struct packed {
        logic                 func;
        logic [31:0]          line_addr;
        logic                 wr_dirty;
        logic [31:0]          timestamp;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic                 evicted_valid;
        logic                 evicted_dirty;
        logic [31:0]          evicted_line_addr;
        logic [31:0]          read_accesses;
        logic [31:0]          read_misses;
        logic [31:0]          write_accesses;
        logic [31:0]          write_misses;
        logic [31:0]          dirty_evictions;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // clear one line entry
        logic load;     // capture request
        logic rd;       // issue way read
        logic step;     // way result returned, evaluate
        logic commit;   // update state and counters
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_way;
        logic rem_done;
        logic clr_last;
    } t_sts;
endpackage

// ===== rtl/sact_if.sv =====
`timescale 1ns / 1ps
interface sact_req_if;
    import sact_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sact_rsp_if;
    import sact_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/set_assoc_cache_tag_store.sv =====
`timescale 1ns / 1ps
// Set-associative cache tag store.
// Request channel (sink): func, line_addr, wr_dirty, timestamp; a transfer
// happens when valid and ready are high at a rising edge.
// Response channel (source): hit, eviction report and the five saturating
// statistics counters as they stand after the request.
// Config port: i_cfg_we, i_cfg_idx (0 policy, 1 set index bits, 2 ways),
// i_cfg_data; write only while idle.
// The ways of the set are read one per cycle from the line RAM while the
// random-victim remainder is worked out four bits a cycle; response valid
// rises once both the scan and the remainder are done.
// One request is in flight at a time; a new request can transfer only once
// the response to the last one has been taken.
// Ready is low while a request is in work or its response is not taken; a
// stalled receiver holds the response and blocks new requests.
// Reset (synchronous, active low) clears counters and config and loads the
// LFSR seed; a clearing pass then zeroes every line entry,
// with request ready held low until it ends.
module set_assoc_cache_tag_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    sact_req_if.sink    req,
    sact_rsp_if.source  rsp
);
    import sact_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sact_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (req.valid),
        .o_in_ready (req.ready),
        .o_out_valid(rsp.valid),
        .i_out_ready(rsp.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    sact_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req.payload),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_rsp     (rsp.payload)
    );
endmodule

// ===== rtl/sact_ram.sv =====
`timescale 1ns / 1ps
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/sact_ctrl.sv =====
`timescale 1ns / 1ps
module sact_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sact_pkg::t_cmd o_cmd,
    input  sact_pkg::t_sts i_sts
);
    import sact_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_oval, n_oval;
    logic       r_rdpend, n_rdpend;

    // input taken when idle and no result waits
    assign o_in_ready  = (r_state == S_IDLE) && !r_oval;
    assign o_out_valid = r_oval;

    always_comb begin
        n_state  = r_state;
        n_oval   = r_oval;
        n_rdpend = 1'b0;
        o_cmd    = '0;
        if (r_oval && i_out_ready) begin
            n_oval = 1'b0;
        end
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    o_cmd.rd   = 1'b1;
                    n_rdpend   = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rdpend) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.last_way) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.rd = 1'b1;
                        n_rdpend = 1'b1;
                    end
                end
            end
            S_DONE: begin
                // wait for the random-victim remainder
                if (i_sts.rem_done) begin
                    o_cmd.commit = 1'b1;
                    n_oval       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_oval   <= 1'b0;
            r_rdpend <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oval   <= n_oval;
            r_rdpend <= n_rdpend;
        end
    end
endmodule

// ===== rtl/sact_dp.sv =====
`timescale 1ns / 1ps
module sact_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [3:0]     i_cfg_data,
    input  sact_pkg::t_req i_req,
    input  sact_pkg::t_cmd i_cmd,
    output sact_pkg::t_sts o_sts,
    output sact_pkg::t_rsp o_rsp
);
    import sact_pkg::*;

    localparam logic [2:0] REM_STEPS = 3'd4;

    // configuration
    logic       r_policy;
    logic [3:0] r_setbits;
    logic [3:0] r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= 1'b0;
            r_setbits <= 4'd8;
            r_ways    <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY:  r_policy  <= i_cfg_data[0];
                CFG_SETBITS: r_setbits <= i_cfg_data;
                CFG_WAYS:    r_ways    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective way count
    logic [WCNT_W-1:0] w_ways;
    always_comb begin
        if (r_ways == 4'd0) begin
            w_ways = WCNT_W'(1);
        end else if (32'(r_ways) > WAY_COUNT) begin
            w_ways = WCNT_W'(WAY_COUNT);
        end else begin
            w_ways = WCNT_W'(r_ways);
        end
    end

    // request capture and set index
    t_req             r_req;
    logic [SET_W-1:0] r_set;
    logic [11:0]      w_imask;
    logic [3:0]       w_b;
    assign w_b     = (r_setbits > 4'd12) ? 4'd12 : r_setbits;
    assign w_imask = 12'((13'd1 << w_b) - 13'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_set <= SET_W'(i_req.line_addr[11:0] & w_imask);
        end
    end

    // line entries in RAM: {valid, dirty, tag, stamp}
    logic [WAY_W-1:0]  r_rway;   // way being read
    logic [WAY_W-1:0]  r_cway;   // way whose data is returned
    logic [LINE_W-1:0] w_raddr, w_waddr, w_cline;
    logic [ENT_W-1:0]  w_rdata, w_wdata;
    logic              w_we;
    logic [WAY_W-1:0]  w_rsel;

    assign w_rsel  = i_cmd.load ? '0 : r_rway;
    assign w_raddr = LINE_W'({(i_cmd.load ? SET_W'(i_req.line_addr[11:0] & w_imask) : r_set),
                              w_rsel});

    sact_ram #(.WIDTH(ENT_W), .DEPTH(LINES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // clearing pass after reset: one line per cycle
    logic [LINE_W-1:0] r_caddr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr <= '0;
        end else if (i_cmd.clr) begin
            r_caddr <= r_caddr + LINE_W'(1);
        end
    end
    assign o_sts.clr_last = r_caddr == LINE_W'(LINES - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_cway <= w_rsel;
            r_rway <= w_rsel + WAY_W'(1);
        end
    end

    assign w_cline = LINE_W'({r_set, r_cway});
    assign o_sts.last_way = (WCNT_W'(r_cway) + WCNT_W'(1)) == w_ways;

    // per-way scan
    logic             r_hit, r_free;
    logic [WAY_W-1:0] r_hway, r_fway, r_lway;
    logic [31:0]      r_best;
    logic [WAY_COUNT-1:0] r_wdirty;
    logic [31:0]      r_wtag [WAY_COUNT];
    logic             w_v;
    assign w_v = w_rdata[65];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.step) begin
            r_wdirty[r_cway] <= w_rdata[64];
            r_wtag[r_cway]   <= w_rdata[63:32];
            if (!r_hit && w_v && w_rdata[63:32] == r_req.line_addr) begin
                r_hit  <= 1'b1;
                r_hway <= r_cway;
            end
            if (!r_free && !w_v) begin
                r_free <= 1'b1;
                r_fway <= r_cway;
            end
            if (r_cway == '0 || w_rdata[31:0] < r_best) begin
                r_best <= w_rdata[31:0];
                r_lway <= r_cway;
            end
        end
    end

    // random victim: next LFSR value modulo way count, long division
    // four bits a cycle starting at the request transfer
    logic [15:0]       r_lfsr, w_lnext;
    logic [15:0]       r_rsrc, n_rsrc;
    logic [WCNT_W-1:0] r_rem, n_rem;
    logic [2:0]        r_rcnt;
    logic [WAY_W-1:0]  w_rway;
    assign w_lnext = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);

    always_comb begin
        logic [WCNT_W:0] v_try;
        n_rsrc = r_rsrc;
        n_rem  = r_rem;
        for (int j = 0; j < 4; j++) begin
            v_try  = {n_rem, n_rsrc[15]};
            n_rsrc = {n_rsrc[14:0], 1'b0};
            if (v_try >= {1'b0, w_ways}) begin
                v_try = v_try - {1'b0, w_ways};
            end
            n_rem = v_try[WCNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsrc <= '0;
            r_rem  <= '0;
            r_rcnt <= '0;
        end else if (i_cmd.load) begin
            r_rsrc <= w_lnext;
            r_rem  <= '0;
            r_rcnt <= '0;
        end else if (r_rcnt != REM_STEPS) begin
            r_rsrc <= n_rsrc;
            r_rem  <= n_rem;
            r_rcnt <= r_rcnt + 3'd1;
        end
    end

    assign o_sts.rem_done = r_rcnt == REM_STEPS;
    assign w_rway         = WAY_W'(r_rem);

    // commit
    logic             w_install, w_evict, w_ndirty;
    logic [WAY_W-1:0] w_vway, w_uway;
    assign w_install = r_req.func == FUNC_INSTALL;
    assign w_evict   = w_install && !r_free;
    assign w_vway    = r_free ? r_fway : (r_policy ? w_rway : r_lway);
    assign w_uway    = w_install ? w_vway : r_hway;
    assign w_ndirty  = w_install ? r_req.wr_dirty : (r_wdirty[r_hway] | r_req.wr_dirty);
    assign w_we      = i_cmd.clr || (i_cmd.commit && (w_install || r_hit));
    assign w_waddr   = i_cmd.clr ? r_caddr : LINE_W'({r_set, w_uway});
    assign w_wdata   = i_cmd.clr ? '0 :
                       {1'b1, w_ndirty, (w_install ? r_req.line_addr : r_wtag[r_hway]),
                        r_req.timestamp};

    logic [31:0] r_cnt [5];
    logic        w_evd;
    assign w_evd = w_evict && r_wdirty[w_vway];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= LFSR_SEED;
            for (int k = 0; k < 5; k++) r_cnt[k] <= '0;
        end else if (i_cmd.commit) begin
            if (w_install) begin
                if (w_evict && r_policy) r_lfsr <= w_lnext;
                if (w_evd && r_cnt[4] != '1) r_cnt[4] <= r_cnt[4] + 32'd1;
            end else begin
                if (r_req.wr_dirty) begin
                    if (r_cnt[2] != '1) r_cnt[2] <= r_cnt[2] + 32'd1;
                    if (!r_hit && r_cnt[3] != '1) r_cnt[3] <= r_cnt[3] + 32'd1;
                end else begin
                    if (r_cnt[0] != '1) r_cnt[0] <= r_cnt[0] + 32'd1;
                    if (!r_hit && r_cnt[1] != '1) r_cnt[1] <= r_cnt[1] + 32'd1;
                end
            end
        end
    end

    // result register; counters read next cycle, so hold event flags
    logic r_ohit, r_oev, r_oevd;
    logic [31:0] r_oaddr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ohit  <= !w_install && r_hit;
            r_oev   <= w_evict;
            r_oevd  <= w_evd;
            r_oaddr <= w_evict ? r_wtag[w_vway] : 32'd0;
        end
    end

    always_comb begin
        o_rsp.hit               = r_ohit;
        o_rsp.evicted_valid     = r_oev;
        o_rsp.evicted_dirty     = r_oevd;
        o_rsp.evicted_line_addr = r_oaddr;
        o_rsp.read_accesses     = r_cnt[0];
        o_rsp.read_misses       = r_cnt[1];
        o_rsp.write_accesses    = r_cnt[2];
        o_rsp.write_misses      = r_cnt[3];
        o_rsp.dirty_evictions   = r_cnt[4];
    end
endmodule

// ===== tb/set_assoc_cache_tag_store_test.sv =====
`timescale 1ns / 1ps
module set_assoc_cache_tag_store_test;
    import sact_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int MAX_CYCLES = 600000;
    localparam int LONG_HOLD = 300;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [3:0] cfg_data;

    sact_req_if req_ch();
    sact_rsp_if rsp_ch();

    set_assoc_cache_tag_store dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch)
    );

    // clock
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // shadow copy of the tag store
    logic [31:0] shadow_tag   [LINES];
    logic        shadow_valid [LINES];
    logic        shadow_dirty [LINES];
    logic [31:0] shadow_stamp [LINES];
    logic [31:0] shadow_cnt   [5];
    logic [15:0] shadow_lfsr;
    logic        shadow_policy;
    logic [3:0]  shadow_setbits;
    logic [3:0]  shadow_ways;

    t_req pending_req[$];
    t_rsp expected_rsp[$];

    int  errors;
    int  cycles;
    int  rsp_count;
    bit  idle_off;      // stretch with no idling on either side
    bit  req_taken;
    bit  rsp_taken;
    int  req_gap;
    int  rsp_stall;
    int  long_hold;
    bit  long_done;

    function automatic void bump_counter(int k);
        if (shadow_cnt[k] != 32'hFFFF_FFFF) shadow_cnt[k] = shadow_cnt[k] + 1;
    endfunction

    // work out the response for one accepted request and update the shadow
    function automatic t_rsp predict_access(t_req r);
        t_rsp o;
        int   ways;
        int   bits;
        int   base;
        int   victim;
        bit   found;
        logic [31:0] best;
        logic [31:0] idx;
        o = '0;
        ways = (shadow_ways < 1) ? 1 : (shadow_ways > WAY_COUNT) ? WAY_COUNT : shadow_ways;
        bits = (shadow_setbits > 12) ? 12 : shadow_setbits;
        idx = r.line_addr & ((32'd1 << bits) - 1);
        base = (idx % SET_COUNT) * WAY_COUNT;
        if (r.func == FUNC_LOOKUP) begin
            for (int i = 0; i < ways; i++) begin
                if (!o.hit && shadow_valid[base+i] && shadow_tag[base+i] == r.line_addr) begin
                    o.hit = 1'b1;
                    shadow_stamp[base+i] = r.timestamp;
                    if (r.wr_dirty) shadow_dirty[base+i] = 1'b1;
                end
            end
            if (r.wr_dirty) begin
                bump_counter(2);
                if (!o.hit) bump_counter(3);
            end else begin
                bump_counter(0);
                if (!o.hit) bump_counter(1);
            end
        end else begin
            victim = 0;
            found = 1'b0;
            for (int i = 0; i < ways; i++) begin
                if (!found && !shadow_valid[base+i]) begin
                    victim = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (shadow_policy) begin
                    shadow_lfsr = {1'b0, shadow_lfsr[15:1]} ^ (shadow_lfsr[0] ? LFSR_TAPS : 16'h0);
                    victim = shadow_lfsr % ways;
                end else begin
                    // oldest stamp, lowest way on ties
                    best = shadow_stamp[base];
                    for (int i = 1; i < ways; i++) begin
                        if (shadow_stamp[base+i] < best) begin
                            best = shadow_stamp[base+i];
                            victim = i;
                        end
                    end
                end
                o.evicted_valid = 1'b1;
                o.evicted_dirty = shadow_dirty[base+victim];
                o.evicted_line_addr = shadow_tag[base+victim];
                if (o.evicted_dirty) bump_counter(4);
            end
            shadow_valid[base+victim] = 1'b1;
            shadow_dirty[base+victim] = r.wr_dirty;
            shadow_tag[base+victim] = r.line_addr;
            shadow_stamp[base+victim] = r.timestamp;
        end
        o.read_accesses   = shadow_cnt[0];
        o.read_misses     = shadow_cnt[1];
        o.write_accesses  = shadow_cnt[2];
        o.write_misses    = shadow_cnt[3];
        o.dirty_evictions = shadow_cnt[4];
        return o;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // request side: accept at the rising edge
    always @(posedge clk) begin
        cycles <= cycles + 1;
        req_taken <= 1'b0;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            expected_rsp.push_back(predict_access(req_ch.payload));
            req_taken <= 1'b1;
        end
    end

    // request driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (req_taken || !req_ch.valid) begin
                if (req_taken) req_gap = idle_off ? 0 : $urandom_range(0, 14);
                if (req_gap == 0 && pending_req.size() > 0) begin
                    req_ch.payload <= pending_req.pop_front();
                    req_ch.valid <= 1'b1;
                    req_gap = idle_off ? 0 : $urandom_range(0, 14);
                end else begin
                    req_ch.valid <= 1'b0;
                    if (req_gap > 0) req_gap--;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk) begin
        rsp_taken <= 1'b0;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_taken <= 1'b1;
            rsp_count <= rsp_count + 1;
            if (expected_rsp.size() == 0) begin
                $display("%0t: response with none expected, got %h", $time, rsp_ch.payload);
                errors++;
            end else begin
                t_rsp e;
                e = expected_rsp.pop_front();
                check_field("hit", e.hit, rsp_ch.payload.hit);
                check_field("evicted_valid", e.evicted_valid, rsp_ch.payload.evicted_valid);
                check_field("evicted_dirty", e.evicted_dirty, rsp_ch.payload.evicted_dirty);
                check_field("evicted_line_addr", e.evicted_line_addr,
                            rsp_ch.payload.evicted_line_addr);
                check_field("read_accesses", e.read_accesses, rsp_ch.payload.read_accesses);
                check_field("read_misses", e.read_misses, rsp_ch.payload.read_misses);
                check_field("write_accesses", e.write_accesses, rsp_ch.payload.write_accesses);
                check_field("write_misses", e.write_misses, rsp_ch.payload.write_misses);
                check_field("dirty_evictions", e.dirty_evictions,
                            rsp_ch.payload.dirty_evictions);
            end
        end
    end

    // response ready: per-transfer stalls plus one long hold-off
    always @(negedge clk) begin
        if (rst_n) begin
            if (!long_done && rsp_count == 400) begin
                long_done = 1'b1;
                long_hold = LONG_HOLD;
            end
            if (long_hold > 0) begin
                long_hold--;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_taken) begin
                rsp_stall = idle_off ? 0 : $urandom_range(0, 14);
                rsp_ch.ready <= (rsp_stall == 0);
                if (rsp_stall > 0) rsp_stall--;
            end else if (rsp_stall > 0) begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // timeout
    always @(posedge clk) begin
        if (cycles > MAX_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    logic [31:0] stamp_now;
    logic [31:0] last_addr;

    task automatic add_req(logic f, logic [31:0] a, logic d, logic [31:0] ts);
        t_req r;
        r.func = f;
        r.line_addr = a;
        r.wr_dirty = d;
        r.timestamp = ts;
        pending_req.push_back(r);
        if (f == FUNC_INSTALL) last_addr = a;
    endtask

    task automatic wait_idle();
        while (pending_req.size() > 0 || req_ch.valid || expected_rsp.size() > 0)
            @(negedge clk);
        repeat (WAY_COUNT + 4) @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            CFG_POLICY:  shadow_policy = val[0];
            CFG_SETBITS: shadow_setbits = val;
            CFG_WAYS:    shadow_ways = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // address from a small pool so that sets fill and lines hit
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        case ($urandom_range(0, 9))
            0: a = $urandom();
            1, 2, 3: a = last_addr;
            default: a = ($urandom_range(0, 9) << 12) | $urandom_range(0, 2)
                         | ($urandom_range(0, 1) << 8);
        endcase
        return a;
    endfunction

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(0, 19))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom();
            default: return stamp_now;
        endcase
    endfunction

    int phase_policy [8] = '{0, 1, 0, 1, 0, 1, 0, 1};
    int phase_setbits[8] = '{8, 8, 0, 12, 15, 4, 2, 9};
    int phase_ways   [8] = '{8, 8, 1, 3, 0, 15, 5, 8};

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_POLICY;
        cfg_data = 4'h0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        errors = 0;
        cycles = 0;
        rsp_count = 0;
        idle_off = 1'b0;
        req_gap = 0;
        rsp_stall = 0;
        long_hold = 0;
        long_done = 1'b0;
        stamp_now = 32'd100;
        last_addr = 32'h0;
        for (int i = 0; i < LINES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            shadow_tag[i] = '0;
            shadow_stamp[i] = '0;
        end
        for (int k = 0; k < 5; k++) shadow_cnt[k] = '0;
        shadow_lfsr = LFSR_SEED;
        shadow_policy = 1'b0;
        shadow_setbits = 4'd8;
        shadow_ways = 4'd8;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, fill of one set, eviction with tied stamps, duplicates
        write_cfg(CFG_UNUSED, 4'hF);
        add_req(FUNC_LOOKUP, 32'h0, 1'b0, 32'h0);
        add_req(FUNC_INSTALL, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h5);
        add_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'h6);
        for (int i = 0; i < WAY_COUNT; i++)
            add_req(FUNC_INSTALL, 32'h100 * i, i[0], 32'd7);
        add_req(FUNC_INSTALL, 32'hABCD_0000, 1'b0, 32'd9);
        add_req(FUNC_INSTALL, 32'hABCD_0000, 1'b1, 32'd10);
        add_req(FUNC_LOOKUP, 32'hABCD_0000, 1'b1, 32'd11);
        add_req(FUNC_LOOKUP, 32'h100, 1'b0, 32'd12);
        add_req(FUNC_INSTALL, 32'h5A5A_A500, 1'b0, 32'd0);
        add_req(FUNC_INSTALL, 32'hA5A5_5A00, 1'b1, 32'd13);
        add_req(FUNC_LOOKUP, 32'h7777_7700, 1'b1, 32'd14);

        // random phases over the register settings
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_cfg(CFG_POLICY, 4'(phase_policy[p]));
            write_cfg(CFG_SETBITS, 4'(phase_setbits[p]));
            write_cfg(CFG_WAYS, 4'(phase_ways[p]));
            idle_off = (p == 2 || p == 6);
            for (int n = 0; n < 192; n++) begin
                stamp_now = stamp_now + $urandom_range(1, 3);
                add_req($urandom_range(0, 2) == 0, pick_addr(), 1'($urandom_range(0, 1)),
                        pick_stamp());
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
